### design/ihws_pkg.sv
// shared types, constants and fixed-point helpers for the interval harmonizer wavetable synth
package ihws_pkg;

  localparam int TABLE_SIZE_DEF  = 4000;
  localparam int NUM_VOICES_DEF  = 7;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int VOICE_SLOTS = 7;
  localparam int VOICE_W     = 3;
  localparam int PHASE_W     = 12;
  localparam int ROOT_W      = 15;
  localparam int OUT_W       = 12;
  localparam int COUNT_W     = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int TRUNC_W = PROD_W - 30;

  localparam int STEPK_W        = 25;
  localparam int STEP_SHIFT     = 27;
  localparam int ANGLE_LO_SHIFT = 24;
  localparam int RECIP_W        = 23;
  localparam int MEAN_SHIFT     = 22;

  localparam logic [CFG_IDX_W-1:0] REG_VOICE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MAJOR  = 2'd1;

  // sine polynomial coefficients, q30
  localparam logic signed [MUL_W-1:0] COEF_C1 = 33'sd1686629713;
  localparam logic signed [MUL_W-1:0] COEF_C3 = -33'sd693598668;
  localparam logic signed [MUL_W-1:0] COEF_C5 = 33'sd85569306;
  localparam logic signed [MUL_W-1:0] COEF_C7 = -33'sd5026996;
  localparam logic signed [MUL_W-1:0] COEF_C9 = 33'sd172272;

  localparam logic signed [MUL_W-1:0] HORNER_COEF [4] = '{COEF_C7, COEF_C5, COEF_C3, COEF_C1};

  localparam logic signed [TRUNC_W-1:0] Q30_S   = 36'sd1073741824;
  localparam logic [30:0]               T_ONE   = 31'h4000_0000;

  // ceil(p * 2^27 / (16 * q)), indexed [voice][major]
  localparam logic [63:0] K_ONE = 64'd1 << 23;
  localparam logic [STEPK_W-1:0] STEP_K [VOICE_SLOTS][2] = '{
    '{STEPK_W'(K_ONE), STEPK_W'(K_ONE)},
    '{STEPK_W'((256 * K_ONE + 242) / 243), STEPK_W'((9 * K_ONE + 7) / 8)},
    '{STEPK_W'((32 * K_ONE + 26) / 27), STEPK_W'((81 * K_ONE + 63) / 64)},
    '{STEPK_W'((4 * K_ONE + 2) / 3), STEPK_W'((4 * K_ONE + 2) / 3)},
    '{STEPK_W'((3 * K_ONE + 1) / 2), STEPK_W'((3 * K_ONE + 1) / 2)},
    '{STEPK_W'((128 * K_ONE + 80) / 81), STEPK_W'((27 * K_ONE + 15) / 16)},
    '{STEPK_W'((16 * K_ONE + 8) / 9), STEPK_W'((243 * K_ONE + 127) / 128)}
  };

  // ceil(2^22 / count)
  localparam logic [63:0] R_ONE = 64'd1 << 22;
  localparam logic [RECIP_W-1:0] RECIP [8] = '{
    RECIP_W'(0),
    RECIP_W'(R_ONE),
    RECIP_W'((R_ONE + 1) / 2),
    RECIP_W'((R_ONE + 2) / 3),
    RECIP_W'((R_ONE + 3) / 4),
    RECIP_W'((R_ONE + 4) / 5),
    RECIP_W'((R_ONE + 5) / 6),
    RECIP_W'((R_ONE + 6) / 7)
  };

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_IDX_K2,
    MUL_IDX_Q0,
    MUL_ROOT_K,
    MUL_TT,
    MUL_PU,
    MUL_PT,
    MUL_MEAN
  } mul_sel_t;

  typedef enum logic [3:0] {
    POST_NONE,
    POST_LO,
    POST_ANGLE,
    POST_STEP,
    POST_U,
    POST_HORNER,
    POST_S,
    POST_ACC,
    POST_MEAN
  } post_op_t;

  typedef struct packed {
    logic               start;
    mul_sel_t           mul_sel;
    post_op_t           post_op;
    logic [VOICE_W-1:0] voice;
    logic [1:0]         coef;
  } cmd_t;

  typedef struct packed {
    logic [VOICE_SLOTS-1:0] voice_on;
  } status_t;

  // product / 2^30, rounded toward zero
  function automatic logic signed [TRUNC_W-1:0] trunc_q30(input logic signed [PROD_W-1:0] x);
    logic signed [TRUNC_W-1:0] q;
    q = $signed(x[PROD_W-1:30]);
    if (x[PROD_W-1] && (x[29:0] != 30'd0)) begin
      q = q + TRUNC_W'(1);
    end
    return q;
  endfunction

endpackage

### design/ihws_ctrl.sv
// sequencer: walks the voices and steps the shared multiplier through each voice's work
module ihws_ctrl
  import ihws_pkg::*;
#(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int CW = $clog2(NUM_VOICES + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_A_LO,
    ST_A_HI,
    ST_STEP,
    ST_TT,
    ST_U,
    ST_HM,
    ST_HA,
    ST_SM,
    ST_SP,
    ST_ACC,
    ST_MEAN,
    ST_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     voice_r, voice_nxt;
  logic [1:0]        hcnt_r, hcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;
  logic              last_voice;
  logic [VOICE_W-1:0] voice_idx;

  assign voice_idx  = VOICE_W'(voice_r);
  assign last_voice = (voice_r == CW'(NUM_VOICES));
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    voice_nxt     = voice_r;
    hcnt_nxt      = hcnt_r;
    cmd.start     = 1'b0;
    cmd.mul_sel   = MUL_NONE;
    cmd.post_op   = POST_NONE;
    cmd.voice     = voice_idx;
    cmd.coef      = hcnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          voice_nxt = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_voice) begin
          state_nxt = ST_MEAN;
        end else if (status.voice_on[voice_idx]) begin
          state_nxt = ST_A_LO;
        end else begin
          voice_nxt = voice_r + CW'(1);
        end
      end
      ST_A_LO: begin
        cmd.mul_sel = MUL_IDX_K2;
        state_nxt   = ST_A_HI;
      end
      ST_A_HI: begin
        cmd.mul_sel = MUL_IDX_Q0;
        cmd.post_op = POST_LO;
        state_nxt   = ST_STEP;
      end
      ST_STEP: begin
        cmd.mul_sel = MUL_ROOT_K;
        cmd.post_op = POST_ANGLE;
        state_nxt   = ST_TT;
      end
      ST_TT: begin
        cmd.mul_sel = MUL_TT;
        cmd.post_op = POST_STEP;
        state_nxt   = ST_U;
      end
      ST_U: begin
        cmd.post_op = POST_U;
        hcnt_nxt    = 2'd0;
        state_nxt   = ST_HM;
      end
      ST_HM: begin
        cmd.mul_sel = MUL_PU;
        state_nxt   = ST_HA;
      end
      ST_HA: begin
        cmd.post_op = POST_HORNER;
        if (hcnt_r == 2'd3) begin
          hcnt_nxt  = 2'd0;
          state_nxt = ST_SM;
        end else begin
          hcnt_nxt  = hcnt_r + 2'd1;
          state_nxt = ST_HM;
        end
      end
      ST_SM: begin
        cmd.mul_sel = MUL_PT;
        state_nxt   = ST_SP;
      end
      ST_SP: begin
        cmd.post_op = POST_S;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        cmd.post_op = POST_ACC;
        voice_nxt   = voice_r + CW'(1);
        state_nxt   = ST_SCAN;
      end
      ST_MEAN: begin
        cmd.mul_sel = MUL_MEAN;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.post_op = POST_MEAN;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((state_r == ST_FIN) && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      voice_r     <= '0;
      hcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      voice_r     <= voice_nxt;
      hcnt_r      <= hcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/ihws_datapath.sv
// datapath: config registers, voice phases, shared multiplier, sine evaluation and mixing
module ihws_datapath
  import ihws_pkg::*;
#(
  parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
  parameter int NUM_VOICES  = NUM_VOICES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [ROOT_W-1:0]     in_root_freq_q4,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [OUT_W-1:0]      out_sample,
  output logic [COUNT_W-1:0]    out_active_count
);

  localparam int VW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int SUM_W = SAMPLE_BITS + 3;
  localparam int RN_W  = 32 + SAMPLE_BITS + 1;
  localparam int PW2   = PHASE_W + 2;

  // floor(idx * 2^32 / T) = idx * A_Q0 + floor(idx * A_K2 / 2^24)
  localparam logic [63:0] TWO32 = 64'd1 << 32;
  localparam logic [63:0] A_Q0  = TWO32 / TABLE_SIZE;
  localparam logic [63:0] A_R0  = TWO32 % TABLE_SIZE;
  localparam logic [63:0] A_K2  = (A_R0 * (64'd1 << ANGLE_LO_SHIFT) + TABLE_SIZE - 1)
                                  / TABLE_SIZE;
  localparam logic [PW2-1:0]         TSIZE      = PW2'(TABLE_SIZE);
  localparam logic [VOICE_SLOTS-1:0] VOICE_MASK = VOICE_SLOTS'((1 << NUM_VOICES) - 1);
  localparam logic [63:0]            ROM_HALF   = 64'd1 << 30;

  logic [VOICE_SLOTS-1:0]    enable_r;
  logic                      major_r;
  logic [ROOT_W-1:0]         root_r;
  logic [PHASE_W-1:0]        phase_r [NUM_VOICES];
  logic signed [PROD_W-1:0]  prod_r;
  logic [PHASE_W-1:0]        lo_r;
  logic [1:0]                quad_r;
  logic [30:0]               t_r;
  logic [PHASE_W-1:0]        step_r;
  logic signed [MUL_W-1:0]   u_r;
  logic signed [MUL_W-1:0]   p_r;
  logic signed [MUL_W-1:0]   s_r;
  logic [SUM_W-1:0]          sum_r;
  logic [COUNT_W-1:0]        count_r;
  logic [OUT_W-1:0]          sample_r;
  logic [COUNT_W-1:0]        active_count_r;

  logic [PHASE_W-1:0]        cur_phase;
  logic signed [MUL_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0]  mul_res;
  logic signed [TRUNC_W-1:0] trunc_v;
  logic signed [TRUNC_W-1:0] horner_sum;
  logic signed [TRUNC_W-1:0] s_neg;
  logic signed [TRUNC_W-1:0] s_clamp;
  logic [31:0]               angle;
  logic [30:0]               t_nxt;
  logic [PW2-1:0]            psum, pw1, pw2;
  logic [PHASE_W-1:0]        phase_nxt;
  logic signed [MUL_W:0]     v_s;
  logic [31:0]               v;
  logic [RN_W-1:0]           rom_num;
  logic [SAMPLE_BITS+1:0]    rom_val;
  logic [OUT_W-1:0]          mean_q;

  assign cfg_ready        = 1'b1;
  assign out_sample       = sample_r;
  assign out_active_count = active_count_r;

  assign status.voice_on = (root_r != '0) ? (enable_r & VOICE_MASK) : '0;

  assign cur_phase = phase_r[cmd.voice[VW-1:0]];

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      MUL_IDX_K2: begin
        op_a = MUL_W'(cur_phase);
        op_b = MUL_W'(A_K2);
      end
      MUL_IDX_Q0: begin
        op_a = MUL_W'(cur_phase);
        op_b = MUL_W'(A_Q0);
      end
      MUL_ROOT_K: begin
        op_a = MUL_W'(root_r);
        op_b = MUL_W'(STEP_K[cmd.voice][major_r]);
      end
      MUL_TT: begin
        op_a = MUL_W'(t_r);
        op_b = MUL_W'(t_r);
      end
      MUL_PU: begin
        op_a = p_r;
        op_b = u_r;
      end
      MUL_PT: begin
        op_a = p_r;
        op_b = MUL_W'(t_r);
      end
      MUL_MEAN: begin
        op_a = MUL_W'(sum_r);
        op_b = MUL_W'(RECIP[count_r]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_res = op_a * op_b;
  assign trunc_v = trunc_q30(prod_r);

  // angle in q32 turns, quadrant split
  assign angle = prod_r[31:0] + 32'(lo_r);
  assign t_nxt = angle[30] ? (T_ONE - {1'b0, angle[29:0]}) : {1'b0, angle[29:0]};

  assign horner_sum = TRUNC_W'(HORNER_COEF[cmd.coef]) + trunc_v;

  always_comb begin
    s_neg   = quad_r[1] ? -trunc_v : trunc_v;
    s_clamp = s_neg;
    if (s_neg > Q30_S) begin
      s_clamp = Q30_S;
    end else if (s_neg < -Q30_S) begin
      s_clamp = -Q30_S;
    end
  end

  // phase advance, step stays below twice the table size
  always_comb begin
    psum      = PW2'(cur_phase) + PW2'(step_r);
    pw1       = (psum >= TSIZE) ? (psum - TSIZE) : psum;
    pw2       = (pw1 >= TSIZE) ? (pw1 - TSIZE) : pw1;
    phase_nxt = pw2[PHASE_W-1:0];
  end

  // rom value = floor((full * (2^30 + s) + 2^30) / 2^31)
  always_comb begin
    v_s     = $signed({s_r[MUL_W-1], s_r}) + $signed((MUL_W+1)'(ROM_HALF));
    v       = v_s[31:0];
    rom_num = RN_W'({v, {SAMPLE_BITS{1'b0}}}) - RN_W'(v) + RN_W'(ROM_HALF);
    rom_val = rom_num[RN_W-1:31];
  end

  assign mean_q = prod_r[MEAN_SHIFT+OUT_W-1:MEAN_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= '0;
      major_r  <= 1'b1;
      for (int i = 0; i < NUM_VOICES; i++) begin
        phase_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VOICE_ENABLE: enable_r <= cfg_data[VOICE_SLOTS-1:0];
          REG_SCALE_MAJOR:  major_r  <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (cmd.post_op == POST_U) begin
        phase_r[cmd.voice[VW-1:0]] <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MUL_NONE) begin
      prod_r <= mul_res;
    end
    if (cmd.start) begin
      root_r  <= in_root_freq_q4;
      sum_r   <= '0;
      count_r <= '0;
    end
    case (cmd.post_op)
      POST_LO: begin
        lo_r <= prod_r[ANGLE_LO_SHIFT+PHASE_W-1:ANGLE_LO_SHIFT];
      end
      POST_ANGLE: begin
        quad_r <= angle[31:30];
        t_r    <= t_nxt;
      end
      POST_STEP: begin
        step_r <= prod_r[STEP_SHIFT+PHASE_W-1:STEP_SHIFT];
      end
      POST_U: begin
        u_r <= MUL_W'(trunc_v);
        p_r <= COEF_C9;
      end
      POST_HORNER: begin
        p_r <= MUL_W'(horner_sum);
      end
      POST_S: begin
        s_r <= MUL_W'(s_clamp);
      end
      POST_ACC: begin
        sum_r   <= sum_r + SUM_W'(rom_val);
        count_r <= count_r + COUNT_W'(1);
      end
      POST_MEAN: begin
        sample_r       <= (count_r == '0) ? '0 : mean_q;
        active_count_r <= count_r;
      end
      default: begin
      end
    endcase
  end

endmodule

### design/interval_harmonizer_wavetable_synth.sv
// top level of the seven-voice interval harmonizer wavetable synth
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_root_freq_q4
//   out      output     out_valid / out_stall out_sample, out_active_count
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// the time from taking an item until out_valid grows with each active voice, as the
// shared 33x33 multiplier does the products of every voice one after another,
// the sine of each voice being a chain of six dependent products on that unit
// synchronous active-low reset clears voice phases, enable to 0 and scale_major to 1
// a new item is taken while a finished result waits in the output register
// the result waits in the last step only when out_stall still holds the previous one
module interval_harmonizer_wavetable_synth
  import ihws_pkg::*;
#(
  parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
  parameter int NUM_VOICES  = NUM_VOICES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ROOT_W-1:0]     in_root_freq_q4,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_W-1:0]      out_sample,
  output logic [COUNT_W-1:0]    out_active_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  ihws_ctrl #(
    .NUM_VOICES (NUM_VOICES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ihws_datapath #(
    .TABLE_SIZE  (TABLE_SIZE),
    .NUM_VOICES  (NUM_VOICES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_root_freq_q4  (in_root_freq_q4),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_sample       (out_sample),
    .out_active_count (out_active_count)
  );

endmodule

### design/ihws_checker.sv
// port-level checks for the harmonizer synth top level, with its bind
module ihws_checker
  import ihws_pkg::*;
#(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [OUT_W-1:0]     out_sample,
  input logic [COUNT_W-1:0]   out_active_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_active_count))
    else $error("stalled result item changed");

  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_active_count == '0) |-> (out_sample == '0))
    else $error("no active voice but nonzero sample");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_active_count <= COUNT_W'(NUM_VOICES)))
    else $error("active count above voice count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while an item is in progress");

endmodule

bind interval_harmonizer_wavetable_synth ihws_checker #(
  .NUM_VOICES (NUM_VOICES)
) u_ihws_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sample       (out_sample),
  .out_active_count (out_active_count)
);

### test/tb.sv
// self-checking testbench for the interval harmonizer wavetable synth
module tb;
  import ihws_pkg::*;

  localparam longint Q30     = 64'sd1073741824;
  localparam longint SIN_K1  = 64'sd1686629713;
  localparam longint SIN_K3  = -64'sd693598668;
  localparam longint SIN_K5  = 64'sd85569306;
  localparam longint SIN_K7  = -64'sd5026996;
  localparam longint SIN_K9  = 64'sd172272;
  localparam int     FULL_SCALE = (1 << SAMPLE_BITS_DEF) - 1;
  localparam int     DRAIN_CYCLES = 140;
  localparam int     MAX_REPORTS = 20;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // interval ratios, indexed [voice][major]
  localparam int RATIO_NUM [VOICE_SLOTS][2] = '{
    '{1, 1}, '{256, 9}, '{32, 81}, '{4, 4}, '{3, 3}, '{128, 27}, '{16, 243}
  };
  localparam int RATIO_DEN [VOICE_SLOTS][2] = '{
    '{1, 1}, '{243, 8}, '{27, 64}, '{3, 3}, '{2, 2}, '{81, 16}, '{9, 128}
  };

  typedef struct packed {
    logic [OUT_W-1:0]   sample;
    logic [COUNT_W-1:0] count;
  } mix_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [ROOT_W-1:0]     in_root_freq_q4;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_W-1:0]      out_sample;
  logic [COUNT_W-1:0]    out_active_count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state
  logic [VOICE_SLOTS-1:0] enable_mask;
  logic                   major_mode;
  logic [PHASE_W-1:0]     tone_phase [VOICE_SLOTS];

  mix_t expected_mix [$];
  int   err_count;
  int   items_sent;
  int   samples_checked;
  int   cfg_writes;
  int   hold_len;
  int   stall_left;
  bit   idle_on;

  interval_harmonizer_wavetable_synth i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_root_freq_q4  (in_root_freq_q4),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_active_count (out_active_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [OUT_W-1:0] sine_entry(input logic [PHASE_W-1:0] idx);
    longint unsigned angle;
    longint unsigned num;
    longint          f;
    longint          t;
    longint          u;
    longint          p;
    longint          s;
    logic [1:0]      quad;
    angle = (longint'(idx) << 32) / longint'(TABLE_SIZE_DEF);
    quad  = angle[31:30];
    f     = angle & 64'h3FFF_FFFF;
    t     = quad[0] ? (Q30 - f) : f;
    u     = (t * t) / Q30;
    p     = SIN_K9;
    p     = SIN_K7 + (p * u) / Q30;
    p     = SIN_K5 + (p * u) / Q30;
    p     = SIN_K3 + (p * u) / Q30;
    p     = SIN_K1 + (p * u) / Q30;
    s     = (p * t) / Q30;
    if (quad[1]) begin
      s = -s;
    end
    if (s > Q30) begin
      s = Q30;
    end
    if (s < -Q30) begin
      s = -Q30;
    end
    num = longint'(FULL_SCALE) * (Q30 + s) + Q30;
    return OUT_W'(num >> 31);
  endfunction

  // mean of the active voices, advancing their phases
  function automatic mix_t mix_voices(input logic [ROOT_W-1:0] root);
    mix_t res;
    int   sum;
    int   cnt;
    int   step;
    sum = 0;
    cnt = 0;
    for (int k = 0; k < VOICE_SLOTS; k++) begin
      if (root != '0 && enable_mask[k]) begin
        step = (int'(root) * RATIO_NUM[k][major_mode]) / (16 * RATIO_DEN[k][major_mode]);
        cnt++;
        sum += int'(sine_entry(tone_phase[k]));
        tone_phase[k] = PHASE_W'((int'(tone_phase[k]) + step) % TABLE_SIZE_DEF);
      end
    end
    res.sample = (cnt != 0) ? OUT_W'(sum / cnt) : '0;
    res.count  = COUNT_W'(cnt);
    return res;
  endfunction

  function automatic logic [ROOT_W-1:0] random_root();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return '0;
      1: return ROOT_W'($urandom_range(1, 64));
      2: return ROOT_W'($urandom_range(32000, 32767));
      default: return ROOT_W'($urandom_range(0, 32767));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_REPORTS) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
    err_count++;
  endtask

  task automatic send_item(input logic [ROOT_W-1:0] root);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_root_freq_q4 <= root;
    do @(posedge clk); while (in_stall);
    expected_mix.push_back(mix_voices(root));
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register writes happen only with the block idle
  task automatic program_regs(input logic [CFG_DATA_W-1:0] enable_data,
                              input logic [CFG_DATA_W-1:0] scale_data,
                              input bit poke_spare);
    logic [CFG_IDX_W-1:0]  idx_list  [4];
    logic [CFG_DATA_W-1:0] data_list [4];
    int                    n;
    drain();
    idx_list[0]  = REG_VOICE_ENABLE;
    data_list[0] = enable_data;
    idx_list[1]  = REG_SCALE_MAJOR;
    data_list[1] = scale_data;
    idx_list[2]  = REG_SPARE_A;
    data_list[2] = CFG_DATA_W'($urandom);
    idx_list[3]  = REG_SPARE_B;
    data_list[3] = CFG_DATA_W'($urandom);
    n = poke_spare ? 4 : 2;
    for (int w = 0; w < n; w++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[w];
      cfg_data  <= data_list[w];
      do @(posedge clk); while (!cfg_ready);
      if (idx_list[w] == REG_VOICE_ENABLE) begin
        enable_mask = data_list[w][VOICE_SLOTS-1:0];
      end else if (idx_list[w] == REG_SCALE_MAJOR) begin
        major_mode = data_list[w][0];
      end
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  // result check and receiver stall
  always @(posedge clk) begin
    mix_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_mix.size() == 0) begin
        report_mismatch("unexpected item, sample", int'(out_sample), -1);
      end else begin
        want = expected_mix.pop_front();
        if (out_sample !== want.sample) begin
          report_mismatch("sample", int'(out_sample), int'(want.sample));
        end
        if (out_active_count !== want.count) begin
          report_mismatch("active_count", int'(out_active_count), int'(want.count));
        end
        samples_checked++;
      end
    end
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic test_reset_state();
    send_item(ROOT_W'(16'h4000));
    send_item(ROOT_W'(1));
    send_item(ROOT_W'(32767));
  endtask

  task automatic test_directed_cases();
    logic [ROOT_W-1:0] roots_major [10] = '{
      ROOT_W'(32767), ROOT_W'(0), ROOT_W'(1), ROOT_W'(15), ROOT_W'(16),
      ROOT_W'(17), ROOT_W'(100), ROOT_W'(15'h2AAA), ROOT_W'(15'h5555), ROOT_W'(4400)
    };
    logic [ROOT_W-1:0] roots_minor [4] = '{
      ROOT_W'(32767), ROOT_W'(1), ROOT_W'(3520), ROOT_W'(7000)
    };
    program_regs(7'h7F, 7'h01, 1'b0);
    foreach (roots_major[i]) send_item(roots_major[i]);
    // upper data bits of the mode register are dropped
    program_regs(7'h7F, 7'h7E, 1'b1);
    foreach (roots_minor[i]) send_item(roots_minor[i]);
    program_regs(7'h00, 7'h01, 1'b0);
    send_item(ROOT_W'(12345));
    program_regs(7'h40, 7'h7F, 1'b1);
    send_item(ROOT_W'(32767));
    send_item(ROOT_W'(2));
  endtask

  // receiver holds off while the sender keeps going
  task automatic test_backpressure();
    program_regs(7'h7F, 7'h00, 1'b0);
    idle_on  = 1'b0;
    hold_len = 400;
    repeat (30) send_item(random_root());
    idle_on = 1'b1;
  endtask

  task automatic test_random_mix();
    logic [CFG_DATA_W-1:0] en;
    logic [CFG_DATA_W-1:0] sc;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: en = 7'h7F;
        1: en = 7'h7F;
        2: en = 7'h01;
        default: en = CFG_DATA_W'($urandom_range(0, 127));
      endcase
      sc = CFG_DATA_W'($urandom);
      if (ph < 2) begin
        sc[0] = (ph == 0);
      end
      program_regs(en, sc, ph[0]);
      idle_on = (ph != 7);
      repeat (180) send_item(random_root());
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_root_freq_q4 <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    enable_mask     = '0;
    major_mode      = 1'b1;
    foreach (tone_phase[k]) tone_phase[k] = '0;
    err_count       = 0;
    items_sent      = 0;
    samples_checked = 0;
    cfg_writes      = 0;
    hold_len        = 0;
    stall_left      = 0;
    idle_on         = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed_cases();
    test_backpressure();
    test_random_mix();
    drain();

    $display("covered %0d ticks and %0d checked samples over %0d register writes,",
             items_sent, samples_checked, cfg_writes);
    $display("both scale modes, voice masks from none to all, long output hold-off");
    if (err_count == 0 && expected_mix.size() == 0) begin
      $display("** interval_harmonizer_wavetable_synth: PASSED **");
    end else begin
      $display("** interval_harmonizer_wavetable_synth: FAILED **");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d samples outstanding", expected_mix.size());
    $display("** interval_harmonizer_wavetable_synth: FAILED **");
    $finish;
  end

endmodule
